### src/tun_pkg.sv
// shared widths, types and constants for the triangle unit normal pipeline
// no dependencies; every other file imports this package
package tun_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int PRE_SHIFT   = (COORD_WIDTH > 24) ? COORD_WIDTH - 24 : 0;
	localparam int DIFF_W      = COORD_WIDTH + 1;
	localparam int EDGE_W      = DIFF_W - PRE_SHIFT;
	localparam int PROD_W      = 2 * EDGE_W;
	localparam int CROSS_W     = PROD_W + 1;
	localparam int MAG_W       = CROSS_W;
	localparam int LEAD_W      = $clog2(MAG_W);
	localparam int NRM_W       = 30;
	localparam int SQ_W        = 2 * NRM_W;
	localparam int SUM_W       = SQ_W + 2;
	localparam int ROOT_W      = SUM_W / 2;
	localparam int NRM_FRAC    = 14;
	localparam int NUM_W       = NRM_W + NRM_FRAC + 1;
	localparam int QUO_W       = 16;
	localparam int DIV_STAGES  = QUO_W + 1;
	localparam int OUT_W       = 16;
	localparam logic [QUO_W-1:0] NRM_ONE = QUO_W'(1 << NRM_FRAC);

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic [MAG_W-1:0] mag_t;
	typedef logic [NRM_W-1:0] nrm_t;
	typedef logic [SUM_W-1:0] sum_t;
	typedef logic [ROOT_W-1:0] root_t;
	typedef logic [QUO_W-1:0] quo_t;

	typedef struct packed {
		logic [2:0][NRM_W-1:0] mag;
		logic [2:0]            neg;
		logic                  degen;
	} side_t;

endpackage

### src/tun_if.sv
// valid/ready channel interfaces for vertex triples and unit normals
// depends on tun_pkg
interface tun_in_if;
	import tun_pkg::*;
	logic   valid;
	logic   ready;
	coord_t corner_x, corner_y, corner_z;
	coord_t right_x, right_y, right_z;
	coord_t below_x, below_y, below_z;

	modport source (output valid, corner_x, corner_y, corner_z, right_x, right_y, right_z,
		below_x, below_y, below_z, input ready);
	modport sink (input valid, corner_x, corner_y, corner_z, right_x, right_y, right_z,
		below_x, below_y, below_z, output ready);
endinterface

interface tun_out_if;
	import tun_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] normal_x, normal_y, normal_z;
	logic                    degenerate;

	modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
	modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

### src/tun_cross.sv
// edge differences, cross product and sign/magnitude split, four stages
// depends on tun_pkg
module tun_cross (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          v_in,
	input  tun_pkg::coord_t [8:0]         pt,
	output logic                          v_out,
	output logic [2:0][tun_pkg::MAG_W-1:0] mag,
	output logic [2:0]                    neg
);
	import tun_pkg::*;

	logic signed [EDGE_W-1:0]  e1_s1 [3];
	logic signed [EDGE_W-1:0]  e2_s1 [3];
	logic signed [PROD_W-1:0]  prod_s2 [6];
	logic signed [CROSS_W-1:0] cr_s3 [3];
	logic [2:0][MAG_W-1:0]     mag_s4;
	logic [2:0]                neg_s4;
	logic [3:0]                v_q;

	function automatic logic signed [EDGE_W-1:0] edge_diff(coord_t a, coord_t b);
		logic signed [DIFF_W-1:0] d;
		d = DIFF_W'(a) - DIFF_W'(b);
		return EDGE_W'(d >>> PRE_SHIFT);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[2:0], v_in};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i] <= edge_diff(pt[3+i], pt[i]);
				e2_s1[i] <= edge_diff(pt[i], pt[6+i]);
			end
			// products for x, y, z components of e1 x e2
			prod_s2[0] <= PROD_W'(e1_s1[1]) * PROD_W'(e2_s1[2]);
			prod_s2[1] <= PROD_W'(e1_s1[2]) * PROD_W'(e2_s1[1]);
			prod_s2[2] <= PROD_W'(e1_s1[2]) * PROD_W'(e2_s1[0]);
			prod_s2[3] <= PROD_W'(e1_s1[0]) * PROD_W'(e2_s1[2]);
			prod_s2[4] <= PROD_W'(e1_s1[0]) * PROD_W'(e2_s1[1]);
			prod_s2[5] <= PROD_W'(e1_s1[1]) * PROD_W'(e2_s1[0]);
			for (int i = 0; i < 3; i++) begin
				cr_s3[i] <= CROSS_W'(prod_s2[2*i]) - CROSS_W'(prod_s2[2*i+1]);
				neg_s4[i] <= cr_s3[i][CROSS_W-1];
				mag_s4[i] <= cr_s3[i][CROSS_W-1] ? MAG_W'(-cr_s3[i]) : MAG_W'(cr_s3[i]);
			end
		end
	end

	assign v_out = v_q[3];
	assign mag   = mag_s4;
	assign neg   = neg_s4;
endmodule

### src/tun_scale.sv
// block normalization of the magnitudes and sum of squares, five stages
// depends on tun_pkg
module tun_scale (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           v_in,
	input  logic [2:0][tun_pkg::MAG_W-1:0] mag,
	input  logic [2:0]                     neg,
	output logic                           v_out,
	output tun_pkg::sum_t                  sum,
	output tun_pkg::side_t                 side
);
	import tun_pkg::*;

	logic [2:0][MAG_W-1:0] mag_s1, mag_s2;
	logic [MAG_W-1:0]      or_s1;
	logic [LEAD_W-1:0]     lead_s2;
	logic [LEAD_W-1:0]     lead_c;
	side_t                 sd_s1, sd_s2, sd_s3, sd_s4, sd_s5;
	logic [2:0][SQ_W-1:0]  sq_s4;
	sum_t                  sum_s5;
	logic [4:0]            v_q;

	// highest set bit of the or of all magnitudes equals that of the largest
	always_comb begin
		lead_c = '0;
		for (int b = 0; b < MAG_W; b++) begin
			if (or_s1[b]) begin
				lead_c = LEAD_W'(b);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[3:0], v_in};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1       <= mag;
			or_s1        <= mag[0] | mag[1] | mag[2];
			sd_s1.mag    <= '0;
			sd_s1.neg    <= neg;
			sd_s1.degen  <= ~|(mag[0] | mag[1] | mag[2]);

			mag_s2  <= mag_s1;
			lead_s2 <= lead_c;
			sd_s2   <= sd_s1;

			// bring the leading bit of the largest magnitude to bit NRM_W-1
			sd_s3.neg   <= sd_s2.neg;
			sd_s3.degen <= sd_s2.degen;
			for (int i = 0; i < 3; i++) begin
				sd_s3.mag[i] <= NRM_W'(({{(NRM_W-1){1'b0}}, mag_s2[i]} << (NRM_W - 1))
					>> lead_s2);
			end

			sd_s4 <= sd_s3;
			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= SQ_W'(sd_s3.mag[i]) * SQ_W'(sd_s3.mag[i]);
			end

			sd_s5  <= sd_s4;
			sum_s5 <= SUM_W'(sq_s4[0]) + SUM_W'(sq_s4[1]) + SUM_W'(sq_s4[2]);
		end
	end

	assign v_out = v_q[4];
	assign sum   = sum_s5;
	assign side  = sd_s5;
endmodule

### src/tun_isqrt.sv
// pipelined integer square root, one root bit per stage
// depends on tun_pkg
module tun_isqrt (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            v_in,
	input  tun_pkg::sum_t   rad,
	input  tun_pkg::side_t  side_in,
	output logic            v_out,
	output tun_pkg::root_t  root,
	output tun_pkg::side_t  side_out
);
	import tun_pkg::*;

	localparam int REM_W = ROOT_W + 1;

	sum_t              rad_sn  [ROOT_W];
	logic [REM_W-1:0]  rem_sn  [ROOT_W];
	root_t             root_sn [ROOT_W];
	side_t             side_sn [ROOT_W];
	logic [ROOT_W-1:0] v_q;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		sum_t               rad_p;
		logic [REM_W-1:0]   rem_p;
		root_t              root_p;
		side_t              side_p;
		logic               v_p;
		logic [REM_W+1:0]   cur;
		logic [REM_W+1:0]   trial;
		logic               ge;

		if (k == 0) begin : g_first
			assign rad_p  = rad;
			assign rem_p  = '0;
			assign root_p = '0;
			assign side_p = side_in;
			assign v_p    = v_in;
		end else begin : g_next
			assign rad_p  = rad_sn[k-1];
			assign rem_p  = rem_sn[k-1];
			assign root_p = root_sn[k-1];
			assign side_p = side_sn[k-1];
			assign v_p    = v_q[k-1];
		end

		assign cur   = {rem_p, rad_p[SUM_W-1:SUM_W-2]};
		assign trial = {1'b0, root_p, 2'b01};
		assign ge    = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en) begin
				v_q[k] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_sn[k]  <= rad_p << 2;
				rem_sn[k]  <= ge ? REM_W'(cur - trial) : REM_W'(cur);
				root_sn[k] <= {root_p[ROOT_W-2:0], ge};
				side_sn[k] <= side_p;
			end
		end
	end

	assign v_out    = v_q[ROOT_W-1];
	assign root     = root_sn[ROOT_W-1];
	assign side_out = side_sn[ROOT_W-1];
endmodule

### src/tun_div.sv
// pipelined rounded divide of one magnitude by the length, one quotient bit per stage
// depends on tun_pkg
module tun_div (
	input  logic           clk,
	input  logic           en,
	input  tun_pkg::nrm_t  mag,
	input  tun_pkg::root_t len,
	output tun_pkg::quo_t  quo
);
	import tun_pkg::*;

	logic [NUM_W-1:0] num_s0;
	root_t            den_s0;
	logic [QUO_W-1:0] lo_sn  [QUO_W];
	root_t            rem_sn [QUO_W];
	root_t            den_sn [QUO_W];
	quo_t             quo_sn [QUO_W];

	// numerator mag * 2^14 + len / 2 gives round half up
	always_ff @(posedge clk) begin
		if (en) begin
			num_s0 <= (NUM_W'(mag) << NRM_FRAC) + NUM_W'(len >> 1);
			den_s0 <= len;
		end
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		logic [QUO_W-1:0] lo_p;
		root_t            rem_p;
		root_t            den_p;
		quo_t             quo_p;
		logic [ROOT_W:0]  cur;
		logic             ge;

		if (k == 0) begin : g_first
			assign lo_p  = num_s0[QUO_W-1:0];
			assign rem_p = ROOT_W'(num_s0[NUM_W-1:QUO_W]);
			assign den_p = den_s0;
			assign quo_p = '0;
		end else begin : g_next
			assign lo_p  = lo_sn[k-1];
			assign rem_p = rem_sn[k-1];
			assign den_p = den_sn[k-1];
			assign quo_p = quo_sn[k-1];
		end

		assign cur = {rem_p, lo_p[QUO_W-1]};
		assign ge  = cur >= {1'b0, den_p};

		always_ff @(posedge clk) begin
			if (en) begin
				lo_sn[k]  <= lo_p << 1;
				rem_sn[k] <= ge ? ROOT_W'(cur - {1'b0, den_p}) : ROOT_W'(cur);
				den_sn[k] <= den_p;
				quo_sn[k] <= {quo_p[QUO_W-2:0], ge};
			end
		end
	end

	assign quo = quo_sn[QUO_W-1];
endmodule

### src/triangle_unit_normal.sv
// top level of the triangle unit normal pipeline
// depends on tun_pkg, tun_if, tun_cross, tun_scale, tun_isqrt, tun_div
//
// usage:
//  src carries one vertex triple per transfer: corner, right and below
//  neighbours, each x/y/z as signed COORD_WIDTH-bit Q4.12 values
//  dst carries one unit normal per transfer: normal_x/y/z in signed Q2.14
//  and degenerate, set (with zero components) when the cross product is zero
//  the result passes the cross, scale, square root and divide stages and the
//  output register on its way from src to dst
//  throughput: one triple per cycle while dst does not stall; every stage is a register stage and
//  the critical path is one 17x17 multiply, a 30x30 square or a compare-subtract
//  of up to 34 bits in the root and divide stages
//  the whole pipeline moves as one: it advances when the output register is
//  empty or is being read; while dst stalls with a result waiting, the
//  pipeline and src.ready hold and nothing is lost or repeated
//  reset clears all valid bits; the data registers need no reset
module triangle_unit_normal (
	input  logic        clk,
	input  logic        arst_n,
	tun_in_if.sink      src,
	tun_out_if.source   dst
);
	import tun_pkg::*;

	logic                  en;
	coord_t [8:0]          pt;
	logic                  v_cr;
	logic [2:0][MAG_W-1:0] mag_cr;
	logic [2:0]            neg_cr;
	logic                  v_sc;
	sum_t                  sum_sc;
	side_t                 side_sc;
	logic                  v_rt;
	root_t                 root_rt;
	side_t                 side_rt;
	quo_t                  quo [3];

	// sign, degenerate and valid ride alongside the dividers
	logic [DIV_STAGES-1:0] v_dq;
	logic [2:0]            neg_dq   [DIV_STAGES];
	logic                  degen_dq [DIV_STAGES];

	logic                    out_v_q;
	logic signed [OUT_W-1:0] nx_q, ny_q, nz_q;
	logic                    degen_q;

	// global advance: output register empty or its transfer happens now
	assign en        = !out_v_q || dst.ready;
	assign src.ready = en;

	assign pt = {src.below_z, src.below_y, src.below_x,
		src.right_z, src.right_y, src.right_x,
		src.corner_z, src.corner_y, src.corner_x};

	tun_cross u_cross (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (src.valid),
		.pt     (pt),
		.v_out  (v_cr),
		.mag    (mag_cr),
		.neg    (neg_cr)
	);

	tun_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (v_cr),
		.mag    (mag_cr),
		.neg    (neg_cr),
		.v_out  (v_sc),
		.sum    (sum_sc),
		.side   (side_sc)
	);

	tun_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (v_sc),
		.rad      (sum_sc),
		.side_in  (side_sc),
		.v_out    (v_rt),
		.root     (root_rt),
		.side_out (side_rt)
	);

	// three divider lanes share the length
	for (genvar i = 0; i < 3; i++) begin : g_div
		tun_div u_div (
			.clk (clk),
			.en  (en),
			.mag (side_rt.mag[i]),
			.len (root_rt),
			.quo (quo[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_dq <= '0;
		end else if (en) begin
			v_dq <= {v_dq[DIV_STAGES-2:0], v_rt};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_dq[0]   <= side_rt.neg;
			degen_dq[0] <= side_rt.degen;
			for (int k = 1; k < DIV_STAGES; k++) begin
				neg_dq[k]   <= neg_dq[k-1];
				degen_dq[k] <= degen_dq[k-1];
			end
		end
	end

	function automatic logic signed [OUT_W-1:0] finish(quo_t q, logic neg, logic degen);
		quo_t sat;
		sat = (q > NRM_ONE) ? NRM_ONE : q;
		if (degen) begin
			return '0;
		end
		return neg ? -OUT_W'(sat) : OUT_W'(sat);
	endfunction

	// output register: saturate at one, apply sign, zero on degenerate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_dq[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_q    <= finish(quo[0], neg_dq[DIV_STAGES-1][0], degen_dq[DIV_STAGES-1]);
			ny_q    <= finish(quo[1], neg_dq[DIV_STAGES-1][1], degen_dq[DIV_STAGES-1]);
			nz_q    <= finish(quo[2], neg_dq[DIV_STAGES-1][2], degen_dq[DIV_STAGES-1]);
			degen_q <= degen_dq[DIV_STAGES-1];
		end
	end

	assign dst.valid      = out_v_q;
	assign dst.normal_x   = nx_q;
	assign dst.normal_y   = ny_q;
	assign dst.normal_z   = nz_q;
	assign dst.degenerate = degen_q;
endmodule

### tb/sv/tb.sv
// self-checking bench for triangle_unit_normal: random vertex triples in, unit normals checked
// depends on tun_pkg, tun_if and the triangle_unit_normal rtl
module tb;
	import tun_pkg::*;

	// one vertex triple as driven on src
	typedef struct {
		coord_t cx, cy, cz, rx, ry, rz, bx, by, bz;
	} triple_t;

	// one unit normal as seen on dst
	typedef struct {
		logic signed [OUT_W-1:0] nx, ny, nz;
		logic                    degen;
	} normal_t;

	logic clk;
	logic arst_n;

	tun_in_if  src_if ();
	tun_out_if dst_if ();

	triangle_unit_normal u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src_if.sink),
		.dst    (dst_if.source)
	);

	triple_t pending_triples[$];
	normal_t expected_normals[$];
	int      error_count = 0;
	bit      stimulus_done = 0;

	// integer square root, floor
	function automatic longint unsigned floor_sqrt(longint unsigned n);
		longint unsigned root, bit_v;
		root  = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > n)
			bit_v >>= 2;
		while (bit_v != 0) begin
			if (n >= root + bit_v) begin
				n    -= root + bit_v;
				root  = (root >> 1) + bit_v;
			end else begin
				root >>= 1;
			end
			bit_v >>= 2;
		end
		return root;
	endfunction

	// unit face normal of one triple, Q2.14, saturated at one
	function automatic normal_t face_normal(triple_t t);
		normal_t         res;
		longint          e1[3], e2[3], cr[3];
		longint unsigned mag[3], peak, sq_sum, len, quo;
		bit              neg[3];
		longint          comp;
		e1[0] = longint'(t.rx) - longint'(t.cx);
		e1[1] = longint'(t.ry) - longint'(t.cy);
		e1[2] = longint'(t.rz) - longint'(t.cz);
		e2[0] = longint'(t.cx) - longint'(t.bx);
		e2[1] = longint'(t.cy) - longint'(t.by);
		e2[2] = longint'(t.cz) - longint'(t.bz);
		// at 16-bit coordinates no edge pre-shift applies
		cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
		cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
		cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
		peak = 0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = cr[i] < 0;
			mag[i] = neg[i] ? longint'(-cr[i]) : cr[i];
			if (mag[i] > peak)
				peak = mag[i];
		end
		if (peak == 0) begin
			res.nx = '0; res.ny = '0; res.nz = '0; res.degen = 1'b1;
			return res;
		end
		// normalize the largest magnitude into [2^29, 2^30)
		while (peak >= (64'd1 << 30)) begin
			peak >>= 1;
			for (int i = 0; i < 3; i++) mag[i] >>= 1;
		end
		while (peak < (64'd1 << 29)) begin
			peak <<= 1;
			for (int i = 0; i < 3; i++) mag[i] <<= 1;
		end
		sq_sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
		len = floor_sqrt(sq_sum);
		if (len == 0)
			len = 1;
		for (int i = 0; i < 3; i++) begin
			quo = ((mag[i] << NRM_FRAC) + (len >> 1)) / len;
			if (quo > (64'd1 << NRM_FRAC))
				quo = 64'd1 << NRM_FRAC;
			comp = neg[i] ? -longint'(quo) : longint'(quo);
			case (i)
				0: res.nx = comp[OUT_W-1:0];
				1: res.ny = comp[OUT_W-1:0];
				default: res.nz = comp[OUT_W-1:0];
			endcase
		end
		res.degen = 1'b0;
		return res;
	endfunction

	function automatic coord_t rand_coord();
		return coord_t'($urandom);
	endfunction

	// mostly small offsets around a corner so the triangle is well formed,
	// sometimes full-range values or collinear points
	function automatic triple_t rand_triple();
		triple_t t;
		int      mode;
		int      span;
		mode = $urandom_range(0, 9);
		span = 1 << $urandom_range(0, 15);
		t.cx = rand_coord(); t.cy = rand_coord(); t.cz = rand_coord();
		if (mode < 3) begin
			t.rx = rand_coord(); t.ry = rand_coord(); t.rz = rand_coord();
			t.bx = rand_coord(); t.by = rand_coord(); t.bz = rand_coord();
		end else if (mode == 3) begin
			// collinear: below is corner mirrored through an integer multiple
			t.rx = t.cx + coord_t'($urandom_range(0, 64) - 32);
			t.ry = t.cy + coord_t'($urandom_range(0, 64) - 32);
			t.rz = t.cz + coord_t'($urandom_range(0, 64) - 32);
			t.bx = coord_t'(t.cx - 2 * (t.rx - t.cx));
			t.by = coord_t'(t.cy - 2 * (t.ry - t.cy));
			t.bz = coord_t'(t.cz - 2 * (t.rz - t.cz));
		end else begin
			t.rx = t.cx + coord_t'($urandom_range(0, 2 * span) - span);
			t.ry = t.cy + coord_t'($urandom_range(0, 2 * span) - span);
			t.rz = t.cz + coord_t'($urandom_range(0, 2 * span) - span);
			t.bx = t.cx + coord_t'($urandom_range(0, 2 * span) - span);
			t.by = t.cy + coord_t'($urandom_range(0, 2 * span) - span);
			t.bz = t.cz + coord_t'($urandom_range(0, 2 * span) - span);
		end
		return t;
	endfunction

	function automatic triple_t make_triple(int cx, int cy, int cz, int rx, int ry, int rz,
		int bx, int by, int bz);
		triple_t t;
		t.cx = coord_t'(cx); t.cy = coord_t'(cy); t.cz = coord_t'(cz);
		t.rx = coord_t'(rx); t.ry = coord_t'(ry); t.rz = coord_t'(rz);
		t.bx = coord_t'(bx); t.by = coord_t'(by); t.bz = coord_t'(bz);
		return t;
	endfunction

	// clock, reset and stimulus list
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		// directed: flat grid facing up, each axis, coincident points,
		// collinear points, the most negative and positive extremes
		pending_triples.push_back(make_triple(0, 0, 0, 4096, 0, 0, 0, -4096, 0));
		pending_triples.push_back(make_triple(0, 0, 0, 0, 4096, 0, 0, 0, -4096));
		pending_triples.push_back(make_triple(0, 0, 0, 0, 0, 4096, -4096, 0, 0));
		pending_triples.push_back(make_triple(0, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_triples.push_back(make_triple(5, 5, 5, 5, 5, 5, 5, 5, 5));
		pending_triples.push_back(make_triple(0, 0, 0, 1, 1, 1, -2, -2, -2));
		pending_triples.push_back(make_triple(-32768, -32768, -32768, 32767, -32768,
			-32768, -32768, 32767, -32768));
		pending_triples.push_back(make_triple(32767, 32767, 32767, -32768, 32767,
			32767, 32767, -32768, 32767));
		pending_triples.push_back(make_triple(-32768, 0, 32767, 32767, -32768, 0,
			0, 32767, -32768));
		pending_triples.push_back(make_triple(32767, -32768, 32767, -32768, 32767,
			-32768, 32767, 32767, -32768));
		pending_triples.push_back(make_triple(-1, -1, -1, 0, -1, -1, -1, -2, -1));
		pending_triples.push_back(make_triple(0, 0, 0, 1, 0, 0, 0, -1, 0));
		pending_triples.push_back(make_triple(0, 0, 0, 1, 1, 0, 1, 0, 1));
		pending_triples.push_back(make_triple(0, 0, 0, 3, 1, 2, -1, 5, 7));
		pending_triples.push_back(make_triple(-32768, -32768, -32768, -32768, -32768,
			-32768, 32767, 32767, 32767));
		pending_triples.push_back(make_triple(0, 0, 0, 1, 2, 3, 4, 5, 6));
		for (int i = 0; i < 1300; i++)
			pending_triples.push_back(rand_triple());
	end

	// driver: src valid with a random hold-off before each triple
	int src_gap;
	initial src_gap = $urandom_range(0, 19);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_if.valid <= 1'b0;
			src_if.corner_x <= '0; src_if.corner_y <= '0; src_if.corner_z <= '0;
			src_if.right_x  <= '0; src_if.right_y  <= '0; src_if.right_z  <= '0;
			src_if.below_x  <= '0; src_if.below_y  <= '0; src_if.below_z  <= '0;
		end else begin
			automatic bit load = 1'b0;
			if (src_if.valid && src_if.ready) begin
				expected_normals.push_back(face_normal('{src_if.corner_x, src_if.corner_y,
					src_if.corner_z, src_if.right_x, src_if.right_y, src_if.right_z,
					src_if.below_x, src_if.below_y, src_if.below_z}));
				// stretches of back-to-back transfers, random gaps otherwise
				src_gap = (pending_triples.size() % 200 < 40) ? 0 : $urandom_range(0, 19);
				load = 1'b1;
			end else if (!src_if.valid) begin
				load = 1'b1;
			end
			if (load) begin
				if (src_gap == 0 && pending_triples.size() != 0) begin
					automatic triple_t t = pending_triples.pop_front();
					src_if.valid    <= 1'b1;
					src_if.corner_x <= t.cx; src_if.corner_y <= t.cy; src_if.corner_z <= t.cz;
					src_if.right_x  <= t.rx; src_if.right_y  <= t.ry; src_if.right_z  <= t.rz;
					src_if.below_x  <= t.bx; src_if.below_y  <= t.by; src_if.below_z  <= t.bz;
				end else begin
					src_if.valid <= 1'b0;
					if (src_gap > 0)
						src_gap--;
					else if (pending_triples.size() == 0)
						stimulus_done = 1'b1;
				end
			end
		end
	end

	// monitor: dst ready with random stalls, compare each transfer in order
	int dst_stall;
	initial dst_stall = $urandom_range(0, 19);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_if.ready <= 1'b0;
		end else begin
			if (dst_if.valid && dst_if.ready) begin
				if (expected_normals.size() == 0) begin
					$display("%0t: unexpected normal %0d %0d %0d degenerate %0b", $time,
						dst_if.normal_x, dst_if.normal_y, dst_if.normal_z, dst_if.degenerate);
					error_count++;
				end else begin
					automatic normal_t exp_n = expected_normals.pop_front();
					if (dst_if.normal_x !== exp_n.nx || dst_if.normal_y !== exp_n.ny ||
						dst_if.normal_z !== exp_n.nz || dst_if.degenerate !== exp_n.degen) begin
						$display("%0t: expected %0d %0d %0d degenerate %0b, got %0d %0d %0d %0b",
							$time, exp_n.nx, exp_n.ny, exp_n.nz, exp_n.degen, dst_if.normal_x,
							dst_if.normal_y, dst_if.normal_z, dst_if.degenerate);
						error_count++;
					end
				end
				dst_stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
			end
			if (dst_stall > 0) begin
				dst_if.ready <= 1'b0;
				dst_stall--;
			end else begin
				dst_if.ready <= 1'b1;
			end
		end
	end

	// end of run: drain, then the pipeline latency plus margin
	initial begin
		wait (stimulus_done && expected_normals.size() == 0);
		repeat (200) @(posedge clk);
		if (error_count == 0)
			$display("triangle_unit_normal verification clean");
		else
			$display("triangle_unit_normal verification failed");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#2000000;
		$display("triangle_unit_normal verification failed");
		$finish;
	end
endmodule
